// ===== sv/rsqv_pkg.sv =====
// Shared constants, types and table functions for the rotated sprite quad generator.
package rsqv_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int FRACTION_BITS    = 4;

   localparam int VERTS_PER_QUAD = 6;
   localparam int VIDX_W         = $clog2(VERTS_PER_QUAD);
   localparam logic [VIDX_W-1:0] LAST_VERTEX = VIDX_W'(VERTS_PER_QUAD - 1);

   localparam int DEGREES_PER_TURN = 360;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int ONE_SHIFT = 14;
   localparam int SINE_ONE  = 1 << ONE_SHIFT;

   localparam int COORD_W  = 16;
   localparam int SIZE_W   = 15;
   localparam int COLOR_W  = 32;
   localparam int MAG_W    = 15;
   localparam int TRIG_W   = 16;
   localparam int PROD_W   = 32;
   localparam int CENTER_W = 18;
   localparam int SUM_W    = 34;
   localparam int OUT_W    = 17;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 96;

   localparam logic signed [OUT_W-1:0] VERTEX_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] VERTEX_MAX = {1'b0, {(OUT_W-1){1'b1}}};

   localparam longint unsigned TAYLOR_DIV [10] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] corner_x;
      logic signed [COORD_W-1:0] corner_y;
      logic [SIZE_W-1:0]         rect_width;
      logic [SIZE_W-1:0]         rect_height;
      logic [SIZE_W-1:0]         texture_width;
      logic [SIZE_W-1:0]         texture_height;
      logic                      mirror;
      logic [COLOR_W-1:0]        color_rgba;
   } geom_type;

   // Q30 angle in radians to Q14 sine magnitude, Taylor series
   function automatic logic [MAG_W-1:0] sine_from_x(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned q;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 0; k < 10; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (!k[0]) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
      end
      q = (sum + 64'd32768) >> 16;
      if (q > 64'(SINE_ONE)) begin
         q = 64'(SINE_ONE);
      end
      return MAG_W'(q);
   endfunction

   // round half up by 2^15 and clamp to the vertex range
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SUM_W-1:0] acc);
      logic signed [SUM_W-1:0]  biased;
      logic signed [SUM_W-16:0] scaled;
      biased = acc + SUM_W'(16384);
      scaled = biased[SUM_W-1:15];
      if (scaled < VERTEX_MIN) begin
         return VERTEX_MIN;
      end else if (scaled > VERTEX_MAX) begin
         return VERTEX_MAX;
      end
      return OUT_W'(scaled);
   endfunction

endpackage

// ===== sv/rotated_sprite_quad_vertices.sv =====
// Rotated sprite quad generator: angle reduction, sine lookup and six-vertex emission.
// A quad's first vertex passes the front stages, the sequencer load register and the result
// register; the other five follow on consecutive cycles when the result side is ready.
// The single result port carries six vertices; the next quad loads as the sixth is emitted.
// Reset clears the stage valid flags, the vertex sequencer and the result valid and last flags;
// the sine table is constant logic and needs no clearing.
module rotated_sprite_quad_vertices #(
   parameter int SINE_TABLE_DEPTH = rsqv_pkg::SINE_TABLE_DEPTH,
   parameter int FRACTION_BITS    = rsqv_pkg::FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // corner_x, corner_y, rect_width, rect_height, texture_width, texture_height,
   // angle_degrees, mirror, color_rgba, zero pad
   input  logic [rsqv_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // vertex_x, vertex_y, tex_u, tex_v, vertex_color
   output logic [rsqv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int FRONT_STAGES = 8;
   localparam int ANGLE_SPAN   = 1 << (rsqv_pkg::COORD_W - 1);
   localparam int DEG          = rsqv_pkg::DEGREES_PER_TURN << FRACTION_BITS;
   localparam int HALF_DEG     = DEG / 2;
   localparam int PH_FULL      = 4 * SINE_TABLE_DEPTH;
   localparam int DW           = $clog2(DEG);
   localparam int OFF          = DEG * ((ANGLE_SPAN + DEG - 1) / DEG);
   localparam int VW           = $clog2(OFF + ANGLE_SPAN);
   localparam int R1           = (1 << VW) / DEG;
   localparam int RW1          = $clog2(R1 + 1);
   localparam int PW1          = VW + RW1;
   localparam int NW           = $clog2(DEG * PH_FULL);
   localparam longint R2       = (longint'(1) << NW) / DEG;
   localparam int RW2          = $clog2(R2 + 1);
   localparam int PW2          = NW + RW2;
   localparam int PHW          = $clog2(PH_FULL + 1);
   localparam int RBW          = $clog2(SINE_TABLE_DEPTH);
   localparam int AW           = $clog2(SINE_TABLE_DEPTH + 1);

   localparam int MAG_W    = rsqv_pkg::MAG_W;
   localparam int TRIG_W   = rsqv_pkg::TRIG_W;
   localparam int PROD_W   = rsqv_pkg::PROD_W;
   localparam int CENTER_W = rsqv_pkg::CENTER_W;
   localparam int SUM_W    = rsqv_pkg::SUM_W;
   localparam int OUT_W    = rsqv_pkg::OUT_W;
   localparam int SIZE_W   = rsqv_pkg::SIZE_W;
   localparam int VIDX_W   = rsqv_pkg::VIDX_W;

   // sine quarter-wave table
   logic [MAG_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

   for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_sine
      localparam longint unsigned PhaseQ30 =
         (rsqv_pkg::HALF_PI_Q30 * i + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
      assign sine_rom[i] = rsqv_pkg::sine_from_x(PhaseQ30);
   end

   // front pipeline control
   logic [FRONT_STAGES-1:0] stage_valid_ff;
   logic [FRONT_STAGES:0]   stage_en;
   rsqv_pkg::geom_type      geom_ff [FRONT_STAGES];
   rsqv_pkg::geom_type      req_geom;
   logic signed [15:0]      req_angle;

   logic                    eng_valid_ff;
   logic [VIDX_W-1:0]       vtx_idx_ff;
   logic                    out_free;
   logic                    emit;
   logic                    eng_done;
   logic                    eng_take;

   always_comb begin
      req_geom.corner_x       = req_tdata[15:0];
      req_geom.corner_y       = req_tdata[31:16];
      req_geom.rect_width     = req_tdata[46:32];
      req_geom.rect_height    = req_tdata[61:47];
      req_geom.texture_width  = req_tdata[76:62];
      req_geom.texture_height = req_tdata[91:77];
      req_angle               = req_tdata[107:92];
      req_geom.mirror         = req_tdata[108];
      req_geom.color_rgba     = req_tdata[140:109];
   end

   always_comb begin
      stage_en[FRONT_STAGES] = eng_take;
      for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            stage_valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < FRONT_STAGES; k++) begin
            if (stage_en[k]) begin
               stage_valid_ff[k] <= stage_valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         geom_ff[0] <= req_geom;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
         if (stage_en[k]) begin
            geom_ff[k] <= geom_ff[k-1];
         end
      end
   end

   // stage 0: angle
   logic signed [15:0] angle_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         angle_ff <= req_angle;
      end
   end

   // stage 1: shift angle positive, estimate turn count
   logic [VW-1:0]  v_in, v_ff;
   logic [PW1-1:0] prod1_in, prod1_ff;

   always_comb begin
      v_in     = {{(VW-16){angle_ff[15]}}, angle_ff} + VW'(OFF);
      prod1_in = {{RW1{1'b0}}, v_in} * PW1'(R1);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         v_ff     <= v_in;
         prod1_ff <= prod1_in;
      end
   end

   // stage 2: partial remainder of angle by a full turn
   logic [RW1-1:0] q1;
   logic [DW:0]    mr_in, mr_ff;

   always_comb begin
      q1    = prod1_ff[PW1-1:VW];
      mr_in = (DW+1)'(v_ff - VW'(q1 * DEG));
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         mr_ff <= mr_in;
      end
   end

   // stage 3: finish reduction, scale to phase units with half-step bias
   logic [DW-1:0] m3;
   logic [NW-1:0] n_in, n_ff;

   always_comb begin
      m3   = (mr_ff >= (DW+1)'(DEG)) ? DW'(mr_ff - (DW+1)'(DEG)) : DW'(mr_ff);
      n_in = NW'(m3 * PH_FULL + HALF_DEG);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         n_ff <= n_in;
      end
   end

   // stage 4: reciprocal multiply for the phase
   logic [PW2-1:0] prod2_in, prod2_ff;
   logic [NW-1:0]  n4_ff;

   always_comb begin
      prod2_in = PW2'(n_ff) * PW2'(R2);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         prod2_ff <= prod2_in;
         n4_ff    <= n_ff;
      end
   end

   // stage 5: phase estimate and remainder
   logic [PHW-1:0] q2_in, q2_ff;
   logic [DW:0]    rem_in, rem_ff;

   always_comb begin
      q2_in  = prod2_ff[NW +: PHW];
      rem_in = (DW+1)'(n4_ff - NW'(q2_in * DEG));
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         q2_ff  <= q2_in;
         rem_ff <= rem_in;
      end
   end

   // stage 6: correct phase, wrap a full turn, split into quadrant and offset
   logic [PHW-1:0] ph;
   logic [1:0]     quad_in, quad_ff;
   logic [RBW-1:0] r_in, r_ff;

   always_comb begin
      ph = q2_ff + PHW'(rem_ff >= (DW+1)'(DEG));
      if (ph >= PHW'(PH_FULL)) begin
         ph = '0;
      end
      if (ph >= PHW'(3 * SINE_TABLE_DEPTH)) begin
         quad_in = 2'd3;
      end else if (ph >= PHW'(2 * SINE_TABLE_DEPTH)) begin
         quad_in = 2'd2;
      end else if (ph >= PHW'(SINE_TABLE_DEPTH)) begin
         quad_in = 2'd1;
      end else begin
         quad_in = 2'd0;
      end
      r_in = RBW'(ph - PHW'(quad_in * SINE_TABLE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         quad_ff <= quad_in;
         r_ff    <= r_in;
      end
   end

   // stage 7: table reads for sine and cosine
   logic [AW-1:0]    sin_addr, cos_addr;
   logic [MAG_W-1:0] sin_mag_ff, cos_mag_ff;
   logic [1:0]       quad7_ff;

   always_comb begin
      sin_addr = quad_ff[0] ? AW'(SINE_TABLE_DEPTH) - AW'(r_ff) : AW'(r_ff);
      cos_addr = quad_ff[0] ? AW'(r_ff) : AW'(SINE_TABLE_DEPTH) - AW'(r_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         sin_mag_ff <= sine_rom[sin_addr];
         cos_mag_ff <= sine_rom[cos_addr];
         quad7_ff   <= quad_ff;
      end
   end

   // vertex sequencer load: signed trig, four products, doubled centre
   rsqv_pkg::geom_type         g7;
   logic signed [TRIG_W-1:0]   sn, cs;
   logic signed [PROD_W-1:0]   wc_in, ws_in, hc_in, hs_in;
   logic signed [PROD_W-1:0]   wc_ff, ws_ff, hc_ff, hs_ff;
   logic signed [CENTER_W-1:0] center_x_in, center_y_in, center_x_ff, center_y_ff;
   logic [SIZE_W-1:0]          eng_tex_w_ff, eng_tex_h_ff;
   logic                       eng_mirror_ff;
   logic [31:0]                eng_color_ff;

   always_comb begin
      g7 = geom_ff[FRONT_STAGES-1];
      sn = signed'({1'b0, sin_mag_ff});
      cs = signed'({1'b0, cos_mag_ff});
      if (quad7_ff[1]) begin
         sn = -sn;
      end
      if (quad7_ff[1] ^ quad7_ff[0]) begin
         cs = -cs;
      end
      wc_in = PROD_W'(signed'({1'b0, g7.rect_width})) * PROD_W'(cs);
      ws_in = PROD_W'(signed'({1'b0, g7.rect_width})) * PROD_W'(sn);
      hc_in = PROD_W'(signed'({1'b0, g7.rect_height})) * PROD_W'(cs);
      hs_in = PROD_W'(signed'({1'b0, g7.rect_height})) * PROD_W'(sn);
      center_x_in = signed'({g7.corner_x[15], g7.corner_x, 1'b0})
                  + signed'({3'b000, g7.rect_width});
      center_y_in = signed'({g7.corner_y[15], g7.corner_y, 1'b0})
                  + signed'({3'b000, g7.rect_height});
   end

   assign out_free = !rsp_tvalid || rsp_tready;
   assign emit     = eng_valid_ff && out_free;
   assign eng_done = emit && (vtx_idx_ff == rsqv_pkg::LAST_VERTEX);
   assign eng_take = !eng_valid_ff || eng_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         eng_valid_ff <= 1'b0;
         vtx_idx_ff   <= '0;
      end else if (eng_take) begin
         eng_valid_ff <= stage_valid_ff[FRONT_STAGES-1];
         vtx_idx_ff   <= '0;
      end else if (emit) begin
         vtx_idx_ff <= vtx_idx_ff + VIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (eng_take) begin
         wc_ff         <= wc_in;
         ws_ff         <= ws_in;
         hc_ff         <= hc_in;
         hs_ff         <= hs_in;
         center_x_ff   <= center_x_in;
         center_y_ff   <= center_y_in;
         eng_tex_w_ff  <= g7.texture_width;
         eng_tex_h_ff  <= g7.texture_height;
         eng_mirror_ff <= g7.mirror;
         eng_color_ff  <= g7.color_rgba;
      end
   end

   // per-vertex corner select, sum, round and clamp
   logic                    right, bottom;
   logic signed [PROD_W-1:0] x_dx, x_dy, y_dx, y_dy;
   logic signed [SUM_W-1:0]  acc_x, acc_y;
   logic signed [OUT_W-1:0]  vertex_x_in, vertex_y_in, vertex_x_ff, vertex_y_ff;
   logic [SIZE_W-1:0]        tex_u_in, tex_v_in, tex_u_ff, tex_v_ff;
   logic [31:0]              vertex_color_ff;
   logic                     rsp_tvalid_ff, rsp_tlast_ff;

   always_comb begin
      right  = 1'b0;
      bottom = 1'b0;
      case (vtx_idx_ff) inside
         VIDX_W'(1): begin
            right = 1'b1;
         end
         VIDX_W'(2), VIDX_W'(5): begin
            right  = 1'b1;
            bottom = 1'b1;
         end
         VIDX_W'(4): begin
            bottom = 1'b1;
         end
         default: begin
         end
      endcase
      x_dx  = right  ? wc_ff : -wc_ff;
      x_dy  = bottom ? hs_ff : -hs_ff;
      y_dx  = right  ? ws_ff : -ws_ff;
      y_dy  = bottom ? hc_ff : -hc_ff;
      acc_x = SUM_W'(signed'({center_x_ff, {rsqv_pkg::ONE_SHIFT{1'b0}}}))
            + SUM_W'(x_dx) - SUM_W'(x_dy);
      acc_y = SUM_W'(signed'({center_y_ff, {rsqv_pkg::ONE_SHIFT{1'b0}}}))
            + SUM_W'(y_dx) + SUM_W'(y_dy);
      vertex_x_in = rsqv_pkg::round_sat(acc_x);
      vertex_y_in = rsqv_pkg::round_sat(acc_y);
      tex_u_in    = (right ^ eng_mirror_ff) ? eng_tex_w_ff : '0;
      tex_v_in    = bottom ? eng_tex_h_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
      end else if (out_free) begin
         rsp_tvalid_ff <= eng_valid_ff;
         rsp_tlast_ff  <= eng_valid_ff && (vtx_idx_ff == rsqv_pkg::LAST_VERTEX);
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         vertex_x_ff     <= vertex_x_in;
         vertex_y_ff     <= vertex_y_in;
         tex_u_ff        <= tex_u_in;
         tex_v_ff        <= tex_v_in;
         vertex_color_ff <= eng_color_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = {vertex_color_ff, tex_v_ff, tex_u_ff, vertex_y_ff, vertex_x_ff};

`ifndef NO_ASSERTIONS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      eng_valid_ff |-> (vtx_idx_ff <= rsqv_pkg::LAST_VERTEX))
      else $error("vertex index beyond the quad");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stage_valid_ff[0])
      else $error("accepted request not held in the first stage");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[FRONT_STAGES-1] && !stage_en[FRONT_STAGES]
      |=> stage_valid_ff[FRONT_STAGES-1])
      else $error("front item dropped while the sequencer was busy");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      eng_done |=> rsp_tvalid_ff && rsp_tlast_ff)
      else $error("sixth vertex not marked last");

   a_sixth_only: assert property (@(posedge clock) disable iff (reset)
      emit && (vtx_idx_ff != rsqv_pkg::LAST_VERTEX) |=> !rsp_tlast_ff)
      else $error("last flag on an inner vertex");
`endif

endmodule
